// File: rtl/rc4_stream_cipher_unit_macros.svh
// Assertion macros for the RC4 stream cipher unit.
`ifndef RC4_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_STREAM_CIPHER_UNIT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define RC4_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define RC4_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher unit.
package rc4_pkg;

  // Permutation size and default key store depth.
  localparam int unsigned SboxDepth = 256;
  localparam int unsigned KeyStoreBytesDefault = 256;

  // Key length after reset.
  localparam logic [8:0] KeyLengthReset = 9'd16;

  // Command codes of an input request.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SCHED = 2'd1,
    CMD_CRYPT = 2'd2
  } rc4_cmd_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KA,
    ST_KB,
    ST_KC,
    ST_KD,
    ST_RJ,
    ST_SWI,
    ST_SWJ
  } rc4_state_e;

  // Input request payload.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_position;
    logic [7:0] data_byte;
    logic       end_of_message;
  } rc4_in_t;

  // Result payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } rc4_out_t;

  // Access request to a memory: one write and one read port.
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } rc4_mem_req_t;

endpackage

// File: rtl/rc4_ram.sv
// Byte-wide synchronous memory with one write port and one registered read port.
module rc4_ram #(
  parameter int unsigned Depth = rc4_pkg::SboxDepth
) (
  input  logic                 clk_i,
  input  rc4_pkg::rc4_mem_req_t req_i,
  output logic [7:0]           rdata_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // Write and read; a read at the written address returns the old contents.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[Aw-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[Aw-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rc4_ctrl.sv
// Sequencer of the RC4 unit: key loading, key schedule and keystream steps.
module rc4_ctrl #(
  parameter int unsigned KeyStoreBytes = rc4_pkg::KeyStoreBytesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rc4_pkg::rc4_in_t      in_data_i,
  input  logic [8:0]            key_len_i,
  input  logic                  res_ready_i,
  output logic                  res_valid_o,
  output rc4_pkg::rc4_out_t     res_data_o,
  output rc4_pkg::rc4_mem_req_t sbox_req_o,
  input  logic [7:0]            sbox_rdata_i,
  output rc4_pkg::rc4_mem_req_t key_req_o,
  input  logic [7:0]            key_rdata_i
);

  localparam int unsigned KeyAw = (KeyStoreBytes > 1) ? $clog2(KeyStoreBytes) : 1;
  localparam logic [8:0] KeyStoreLimit = 9'(KeyStoreBytes);

  rc4_pkg::rc4_state_e state_q, state_d;
  logic [7:0]       i_q, j_q;
  logic [KeyAw-1:0] k_q;
  logic             sched_q;
  logic [7:0]       si_q, sj_q, data_q;
  logic             eom_q, hit_i_q, hit_j_q;

  logic       accept;
  logic [7:0] j_ksa, j_prga, t_sum, ks;
  logic [8:0] k_inc;

  assign accept = in_valid_i && (state_q == rc4_pkg::ST_IDLE);
  assign in_stall_o = (state_q != rc4_pkg::ST_IDLE);

  // Index arithmetic: the j and t sums are modulo 256, the key counter step is 9 bits wide.
  assign j_ksa  = j_q + sbox_rdata_i + key_rdata_i;
  assign j_prga = j_q + sbox_rdata_i;
  assign t_sum  = si_q + sbox_rdata_i;
  assign k_inc  = 9'(k_q) + 9'd1;

  // Keystream byte, forwarded where it hits an entry just swapped.
  assign ks = hit_j_q ? si_q : (hit_i_q ? sj_q : sbox_rdata_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          case (rc4_pkg::rc4_cmd_e'(in_data_i.command))
            rc4_pkg::CMD_SCHED: state_d = rc4_pkg::ST_INIT;
            rc4_pkg::CMD_CRYPT: begin
              if (sched_q) state_d = rc4_pkg::ST_RJ;
            end
            default: state_d = rc4_pkg::ST_IDLE;
          endcase
        end
      end
      rc4_pkg::ST_INIT: begin
        if (i_q == 8'hFF) state_d = rc4_pkg::ST_KA;
      end
      rc4_pkg::ST_KA: state_d = rc4_pkg::ST_KB;
      rc4_pkg::ST_KB: state_d = rc4_pkg::ST_KC;
      rc4_pkg::ST_KC: state_d = rc4_pkg::ST_KD;
      rc4_pkg::ST_KD: begin
        state_d = (i_q == 8'hFF) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KA;
      end
      rc4_pkg::ST_RJ:  state_d = rc4_pkg::ST_SWI;
      rc4_pkg::ST_SWI: state_d = rc4_pkg::ST_SWJ;
      rc4_pkg::ST_SWJ: begin
        if (res_ready_i) state_d = rc4_pkg::ST_IDLE;
      end
      default: state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  // Memory requests and result for each state.
  always_comb begin
    sbox_req_o  = '0;
    key_req_o   = '0;
    res_valid_o = 1'b0;
    case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          case (rc4_pkg::rc4_cmd_e'(in_data_i.command))
            rc4_pkg::CMD_LOAD: begin
              key_req_o.we    = (9'(in_data_i.key_position) < KeyStoreLimit);
              key_req_o.waddr = in_data_i.key_position;
              key_req_o.wdata = in_data_i.data_byte;
            end
            rc4_pkg::CMD_CRYPT: begin
              sbox_req_o.re    = sched_q;
              sbox_req_o.raddr = i_q + 8'd1;
            end
            default: ;
          endcase
        end
      end
      // Identity fill, one entry a cycle.
      rc4_pkg::ST_INIT: begin
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = i_q;
        sbox_req_o.wdata = i_q;
      end
      rc4_pkg::ST_KA: begin
        sbox_req_o.re   = 1'b1;
        sbox_req_o.raddr = i_q;
        key_req_o.re    = 1'b1;
        key_req_o.raddr = 8'(k_q);
      end
      rc4_pkg::ST_KB: begin
        sbox_req_o.re    = 1'b1;
        sbox_req_o.raddr = j_ksa;
      end
      rc4_pkg::ST_KC: begin
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = i_q;
        sbox_req_o.wdata = sbox_rdata_i;
      end
      rc4_pkg::ST_KD: begin
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = j_q;
        sbox_req_o.wdata = si_q;
      end
      rc4_pkg::ST_RJ: begin
        sbox_req_o.re    = 1'b1;
        sbox_req_o.raddr = j_prga;
      end
      // First half of the swap, with the keystream read issued alongside.
      rc4_pkg::ST_SWI: begin
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = i_q;
        sbox_req_o.wdata = sbox_rdata_i;
        sbox_req_o.re    = 1'b1;
        sbox_req_o.raddr = t_sum;
      end
      // Second half of the swap; repeating it while the result waits is harmless.
      rc4_pkg::ST_SWJ: begin
        sbox_req_o.we    = 1'b1;
        sbox_req_o.waddr = j_q;
        sbox_req_o.wdata = si_q;
        res_valid_o      = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_data_o.out_byte = data_q ^ ks;
  assign res_data_o.last_out = eom_q;

  // Control state: state, indices, key counter and schedule flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rc4_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      sched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        rc4_pkg::ST_IDLE: begin
          if (accept) begin
            case (rc4_pkg::rc4_cmd_e'(in_data_i.command))
              rc4_pkg::CMD_SCHED: begin
                i_q <= '0;
                j_q <= '0;
                k_q <= '0;
              end
              rc4_pkg::CMD_CRYPT: begin
                if (sched_q) i_q <= i_q + 8'd1;
              end
              default: ;
            endcase
          end
        end
        rc4_pkg::ST_INIT: i_q <= i_q + 8'd1;
        rc4_pkg::ST_KB:   j_q <= j_ksa;
        rc4_pkg::ST_KD: begin
          i_q <= i_q + 8'd1;
          k_q <= (k_inc == key_len_i) ? '0 : k_inc[KeyAw-1:0];
          if (i_q == 8'hFF) begin
            j_q     <= '0;
            sched_q <= 1'b1;
          end
        end
        rc4_pkg::ST_RJ: j_q <= j_prga;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i.data_byte;
      eom_q  <= in_data_i.end_of_message;
    end
    if (state_q == rc4_pkg::ST_KB || state_q == rc4_pkg::ST_RJ) begin
      si_q <= sbox_rdata_i;
    end
    if (state_q == rc4_pkg::ST_SWI) begin
      sj_q    <= sbox_rdata_i;
      hit_i_q <= (t_sum == i_q);
      hit_j_q <= (t_sum == j_q);
    end
  end

endmodule

// File: rtl/rc4_stream_cipher_unit.sv
// RC4 stream cipher unit: top level with configuration and output register.
// A crypt request passes through the controller in order: read i at acceptance, read j,
// swap with keystream read, then swap and result, where it waits for the output register;
// the order is set by the single permutation read port. Load and ignored requests finish
// at acceptance; a schedule request fills 256 entries, then runs the KSA steps (KA to KD).
// Reset clears the indices, the schedule flag and key length (16); memories are
// not cleared.
`include "rc4_stream_cipher_unit_macros.svh"

module rc4_stream_cipher_unit #(
  parameter int unsigned KeyStoreBytes = rc4_pkg::KeyStoreBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rc4_pkg::rc4_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rc4_pkg::rc4_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [8:0]        cfg_data_i
);

  localparam logic [8:0] KeyStoreLimit = 9'(KeyStoreBytes);

  logic [8:0] key_length_q, key_len;
  logic       res_valid, res_ready;
  logic       out_valid_q, out_valid_d;
  logic       load_acc;
  rc4_pkg::rc4_out_t     res_data, out_data_q;
  rc4_pkg::rc4_mem_req_t sbox_req, key_req;
  logic [7:0] sbox_rdata, key_rdata;

  // Key length register, always ready for a write request.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= rc4_pkg::KeyLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_length_q <= cfg_data_i;
    end
  end

  // Effective key length: zero counts as one, large values saturate.
  assign key_len = (key_length_q == 9'd0) ? 9'd1 :
                   ((key_length_q > KeyStoreLimit) ? KeyStoreLimit : key_length_q);

  rc4_ctrl #(
    .KeyStoreBytes(KeyStoreBytes)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .key_len_i    (key_len),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_data_o   (res_data),
    .sbox_req_o   (sbox_req),
    .sbox_rdata_i (sbox_rdata),
    .key_req_o    (key_req),
    .key_rdata_i  (key_rdata)
  );

  rc4_ram #(
    .Depth(rc4_pkg::SboxDepth)
  ) u_sbox (
    .clk_i   (clk_i),
    .req_i   (sbox_req),
    .rdata_o (sbox_rdata)
  );

  rc4_ram #(
    .Depth(KeyStoreBytes)
  ) u_key (
    .clk_i   (clk_i),
    .req_i   (key_req),
    .rdata_o (key_rdata)
  );

  // Output register: takes a result when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A key load request taken at this edge.
  assign load_acc = in_valid_i && !in_stall_o && (in_data_i.command == rc4_pkg::CMD_LOAD);

  // A result only comes from a request still at work.
  `RC4_ASSERT(a_res_while_busy, !res_valid || in_stall_o, "result outside a crypt request")
  // A key load completes in the cycle it is accepted.
  `RC4_ASSERT_NEXT(a_load_single, load_acc, !in_stall_o, "key load did not complete at once")
  // A result that cannot be taken is held.
  `RC4_ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid, "pending result dropped")

endmodule

// File: sim/tb_rc4_stream_cipher_unit.sv
// Self-checking testbench of the RC4 stream cipher unit: directed table, then random key sessions.
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_unit;

  localparam int unsigned TableSize = rc4_pkg::SboxDepth;
  // Command value with no meaning; the unit must drop such a request.
  localparam logic [1:0] CmdUnused = 2'd3;
  // A key schedule leaves no result behind it.
  localparam int unsigned SettleCycles = 1400;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TotalRequests = 800;
  localparam int unsigned RunLimitNs = 2_000_000;

  typedef enum logic {ROW_REQ, ROW_KEY_LENGTH} row_kind_e;

  // One row of the directed table; a fixed row carries its own expectation.
  typedef struct {
    row_kind_e         kind;
    rc4_pkg::rc4_in_t  req;
    logic [8:0]        key_length;
    bit                fixed;
    bit                fixed_has;
    rc4_pkg::rc4_out_t fixed_res;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  rc4_pkg::rc4_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  rc4_pkg::rc4_out_t out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [8:0]        cfg_data_i = '0;

  // Cipher state as the unit should hold it.
  logic [7:0] sbox [TableSize];
  logic [7:0] key_bytes [TableSize];
  bit         key_loaded [TableSize];
  logic [7:0] ptr_first;
  logic [7:0] ptr_second;
  bit         keyed;
  logic [8:0] key_length;

  rc4_pkg::rc4_out_t expected_bytes [$];
  stim_row_t         directed_rows [$];
  int                requests_done = 0;
  int                mismatches = 0;
  int                holds_asked = 0;
  int                holds_served = 0;
  int                hold_left = 0;

  rc4_stream_cipher_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic rc4_pkg::rc4_in_t make_req(input logic [1:0] command,
                                                input logic [7:0] position,
                                                input logic [7:0] data, input logic eom);
    rc4_pkg::rc4_in_t r;
    r.command = command;
    r.key_position = position;
    r.data_byte = data;
    r.end_of_message = eom;
    return r;
  endfunction

  // The idling pattern moves on with the number of requests taken so far, dropped ones apart.
  function automatic int idle_phase();
    if (requests_done < TotalRequests / 3) return 0;
    if (requests_done < 2 * TotalRequests / 3) return 1;
    return 2;
  endfunction

  function automatic int send_gap_pct();
    case (idle_phase())
      0: return 33;
      1: return 60;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_phase())
      0: return 60;
      1: return 33;
      default: return 0;
    endcase
  endfunction

  // A key length of zero counts as one; anything past the store is clipped to it.
  function automatic int used_key_bytes();
    if (key_length == 0) return 1;
    if (key_length > rc4_pkg::KeyStoreBytesDefault) return rc4_pkg::KeyStoreBytesDefault;
    return key_length;
  endfunction

  // Applies one request to the cipher state and returns whether it yields a byte.
  function automatic bit cipher_step(input rc4_pkg::rc4_in_t req,
                                     output rc4_pkg::rc4_out_t res);
    int         len;
    int         k;
    logic [7:0] swap;
    logic [7:0] pick;
    logic [7:0] mix;
    res = '0;
    cipher_step = 1'b0;
    case (req.command)
      rc4_pkg::CMD_LOAD: begin
        key_bytes[req.key_position] = req.data_byte;
        key_loaded[req.key_position] = 1'b1;
      end
      rc4_pkg::CMD_SCHED: begin
        len = used_key_bytes();
        for (k = 0; k < TableSize; k++) sbox[k] = 8'(k);
        mix = '0;
        for (k = 0; k < TableSize; k++) begin
          mix = mix + sbox[k] + key_bytes[k % len];
          swap = sbox[k];
          sbox[k] = sbox[mix];
          sbox[mix] = swap;
        end
        ptr_first = '0;
        ptr_second = '0;
        keyed = 1'b1;
      end
      rc4_pkg::CMD_CRYPT: begin
        // Without a schedule the request is dropped and nothing changes.
        if (keyed) begin
          ptr_first = ptr_first + 8'd1;
          ptr_second = ptr_second + sbox[ptr_first];
          swap = sbox[ptr_first];
          sbox[ptr_first] = sbox[ptr_second];
          sbox[ptr_second] = swap;
          pick = sbox[ptr_first] + sbox[ptr_second];
          res.out_byte = req.data_byte ^ sbox[pick];
          res.last_out = req.end_of_message;
          cipher_step = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one request, waits until it is taken and records what it should give.
  task automatic offer_request(input rc4_pkg::rc4_in_t req, input bit fixed,
                               input bit fixed_has, input rc4_pkg::rc4_out_t fixed_res);
    rc4_pkg::rc4_out_t res;
    bit                has_res;
    bit                counts;
    if ($urandom_range(99) < send_gap_pct()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct());
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    counts = (req.command != CmdUnused) && (req.command != rc4_pkg::CMD_CRYPT || keyed);
    has_res = cipher_step(req, res);
    if (counts) requests_done++;
    if (fixed) begin
      has_res = fixed_has;
      res = fixed_res;
    end
    if (has_res) expected_bytes.push_back(res);
  endtask

  // Lets every outstanding byte arrive and any schedule finish.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_key_length(input logic [8:0] value);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    key_length = value;
  endtask

  // Receiver: random stalls, and one long hold-off when the stimulus asks for it.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  // Every byte taken from the unit is compared with the oldest one outstanding.
  always @(posedge clk_i) begin
    rc4_pkg::rc4_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected none, actual %02h", out_data_o.out_byte);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, out_data_o.out_byte);
          mismatches++;
        end
        if (out_data_o.last_out !== want.last_out) begin
          $error("last_out: expected %0b, actual %0b", want.last_out, out_data_o.last_out);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(RunLimitNs);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [8:0] len;
    int         session;
    int         k;
    int         pick;

    keyed = 1'b0;
    ptr_first = '0;
    ptr_second = '0;
    key_length = rc4_pkg::KeyLengthReset;

    // Dropped requests first, then the classic "Key" / "Plaintext" vector, then the
    // shortest key with extreme data and positions.
    directed_rows = '{
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'hFF, 8'hFF, 1'b1), 9'd0, 1'b1, 1'b0, '0},
      '{ROW_REQ, make_req(CmdUnused, 8'hFF, 8'hFF, 1'b1), 9'd0, 1'b1, 1'b0, '0},
      '{ROW_KEY_LENGTH, '0, 9'd3, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_LOAD, 8'd0, 8'h4B, 1'b0), 9'd0, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_LOAD, 8'd1, 8'h65, 1'b0), 9'd0, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_LOAD, 8'd2, 8'h79, 1'b0), 9'd0, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_SCHED, 8'd0, 8'd0, 1'b0), 9'd0, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h50, 1'b0), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'hBB, 1'b0}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h6C, 1'b0), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'hF3, 1'b0}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h61, 1'b0), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'h16, 1'b0}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h69, 1'b0), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'hE8, 1'b0}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h6E, 1'b0), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'hD9, 1'b0}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h74, 1'b0), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'h40, 1'b0}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h65, 1'b0), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'hAF, 1'b0}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h78, 1'b0), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'h0A, 1'b0}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'd0, 8'h74, 1'b1), 9'd0, 1'b1, 1'b1,
        rc4_pkg::rc4_out_t'{8'hD3, 1'b1}},
      '{ROW_REQ, make_req(rc4_pkg::CMD_LOAD, 8'hFF, 8'h00, 1'b0), 9'd0, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_LOAD, 8'h00, 8'hFF, 1'b1), 9'd0, 1'b0, 1'b0, '0},
      '{ROW_KEY_LENGTH, '0, 9'd0, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_SCHED, 8'hFF, 8'hFF, 1'b1), 9'd0, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'h00, 8'h00, 1'b0), 9'd0, 1'b0, 1'b0, '0},
      '{ROW_REQ, make_req(CmdUnused, 8'h00, 8'h00, 1'b0), 9'd0, 1'b1, 1'b0, '0},
      '{ROW_REQ, make_req(rc4_pkg::CMD_CRYPT, 8'hFF, 8'hFF, 1'b1), 9'd0, 1'b0, 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_KEY_LENGTH) begin
        write_key_length(directed_rows[r].key_length);
      end else begin
        offer_request(directed_rows[r].req, directed_rows[r].fixed, directed_rows[r].fixed_has,
                      directed_rows[r].fixed_res);
      end
    end

    // Random sessions: set a key length, load the key, schedule it, then stream bytes
    // with some dropped requests, key loads and reschedules mixed in.
    session = 0;
    while (requests_done < TotalRequests) begin
      case (session)
        0: len = 9'($urandom_range(2, 40));
        1: len = 9'd1;
        2: len = 9'h1FF;
        3: len = 9'd256;
        4: len = 9'd0;
        default: len = 9'($urandom_range(0, 511));
      endcase
      write_key_length(len);
      repeat ($urandom_range(0, 6)) begin
        offer_request(make_req(rc4_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 1'($urandom)),
                      1'b0, 1'b0, '0);
      end
      // The schedule must only read key bytes that have been loaded.
      for (k = 0; k < used_key_bytes(); k++) begin
        if (!key_loaded[k]) begin
          offer_request(make_req(rc4_pkg::CMD_LOAD, 8'(k), 8'($urandom), 1'($urandom)),
                        1'b0, 1'b0, '0);
        end
      end
      offer_request(make_req(rc4_pkg::CMD_SCHED, 8'($urandom), 8'($urandom), 1'($urandom)),
                    1'b0, 1'b0, '0);
      // Once idling stops, hold the receiver off so that the unit backs up.
      if (idle_phase() == 2 && holds_asked == 0) holds_asked++;
      repeat ($urandom_range(20, 90)) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          offer_request(make_req(rc4_pkg::CMD_CRYPT, 8'($urandom), 8'($urandom),
                                 ($urandom_range(7) == 0)), 1'b0, 1'b0, '0);
        end else if (pick < 92) begin
          offer_request(make_req(CmdUnused, 8'($urandom), 8'($urandom), 1'($urandom)),
                        1'b0, 1'b0, '0);
        end else if (pick < 97) begin
          offer_request(make_req(rc4_pkg::CMD_LOAD, 8'($urandom), 8'($urandom),
                                 1'($urandom)), 1'b0, 1'b0, '0);
        end else begin
          offer_request(make_req(rc4_pkg::CMD_SCHED, 8'($urandom), 8'($urandom),
                                 1'($urandom)), 1'b0, 1'b0, '0);
        end
      end
      session++;
    end

    settle_idle();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_ctrl.sv
rtl/rc4_stream_cipher_unit.sv
sim/tb_rc4_stream_cipher_unit.sv
